// ===== rtl/fmpf_pkg.sv =====
package fmpf_pkg;

   localparam int MaxRulesDefault = 16;

   localparam logic [7:0] ProtoTcp = 8'd6;
   localparam logic [7:0] ProtoUdp = 8'd17;

   typedef enum logic [1:0] {
      OP_CLASSIFY = 2'd0,
      OP_ADD      = 2'd1,
      OP_DELETE   = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_BAD_IDX  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      RP_ANY = 2'd0,
      RP_TCP = 2'd1,
      RP_UDP = 2'd2,
      RP_ALT = 2'd3
   } rproto_type;

   typedef enum logic [1:0] {
      FS_IDLE = 2'd0,
      FS_WALK = 2'd1,
      FS_DONE = 2'd2
   } fsm_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [1:0]  direction;
      logic [7:0]  packet_protocol;
      logic [1:0]  rule_protocol;
      logic [31:0] source_address;
      logic [31:0] source_mask;
      logic [15:0] source_port;
      logic [31:0] dest_address;
      logic [31:0] dest_mask;
      logic [15:0] destination_port;
      logic        block_action;
      logic [4:0]  delete_index;
   } req_type;

   typedef struct packed {
      logic       drop;
      logic       matched;
      logic [4:0] match_position;
      logic [1:0] status;
      logic [4:0] rules_held;
   } rsp_type;

   // One stored rule.
   typedef struct packed {
      logic [31:0] src_addr;
      logic [31:0] src_mask;
      logic [31:0] dst_addr;
      logic [31:0] dst_mask;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [1:0]  dir;
      logic [1:0]  proto;
      logic        act;
   } rule_type;

   // Packet key carried down the chain.
   typedef struct packed {
      logic [1:0]  dir;
      logic [7:0]  proto;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] sport;
      logic [15:0] dport;
   } key_type;

   // Control from the sequencer to every cell.
   typedef struct packed {
      logic load;   // capture key into cell 0 chain
      logic append; // write the new rule at tail
      logic remove; // shift rules above the removed slot down
   } cell_ctl_type;

   // Leading-ones prefix compare; a zero mask means all bits.
   function automatic logic prefix_equal(input logic [31:0] pkt,
                                         input logic [31:0] rule,
                                         input logic [31:0] mask);
      logic [31:0] sel;
      logic        run;
      sel = '0;
      run = 1'b1;
      if (mask == 32'd0) begin
         sel = '1;
      end else begin
         for (int i = 31; i >= 0; i--) begin
            run    = run & mask[i];
            sel[i] = run;
         end
      end
      return ((pkt ^ rule) & sel) == 32'd0;
   endfunction

   function automatic logic rule_hit(input rule_type r, input key_type k);
      logic ok;
      ok = (r.dir == k.dir);
      if (rproto_type'(r.proto) == RP_TCP && k.proto != ProtoTcp) ok = 1'b0;
      if (rproto_type'(r.proto) == RP_UDP && k.proto != ProtoUdp) ok = 1'b0;
      if (r.src_addr != 32'd0 && !prefix_equal(k.src_addr, r.src_addr, r.src_mask))
         ok = 1'b0;
      if (r.dst_addr != 32'd0 && !prefix_equal(k.dst_addr, r.dst_addr, r.dst_mask))
         ok = 1'b0;
      if (r.sport != 16'd0 && r.sport != k.sport) ok = 1'b0;
      if (r.dport != 16'd0 && r.dport != k.dport) ok = 1'b0;
      return ok;
   endfunction

endpackage

// ===== rtl/fmpf_cell.sv =====
// One rule slot. It holds a rule and compares the key that arrives from
// its left neighbor; the key and the running verdict move one cell a cycle.
module fmpf_cell #(
   parameter int IdxW = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  fmpf_pkg::cell_ctl_type ctl,
   input  logic                   is_tail,    // this slot equals the rule count
   input  logic                   above_del,  // 1-based slot position >= removed index
   input  fmpf_pkg::rule_type     add_rule,
   input  fmpf_pkg::rule_type     upper_rule, // rule of the next cell (own rule for the top cell)
   input  logic [IdxW-1:0]        my_pos,     // 1-based position
   input  logic                   active,     // slot holds a live rule and key direction is 1 or 2
   input  logic                   key_vld_i,
   input  fmpf_pkg::key_type      key_i,
   input  logic                   hit_i,
   input  logic [IdxW-1:0]        pos_i,
   input  logic                   drop_i,
   output fmpf_pkg::rule_type     rule_o,
   output logic                   key_vld_o,
   output fmpf_pkg::key_type      key_o,
   output logic                   hit_o,
   output logic [IdxW-1:0]        pos_o,
   output logic                   drop_o
);

   fmpf_pkg::rule_type rule_ff, rule_in;
   fmpf_pkg::key_type  key_ff;
   logic               kv_ff, hit_ff, drop_ff;
   logic [IdxW-1:0]    pos_ff;
   logic               take;

   always_comb begin
      rule_in = rule_ff;
      if (ctl.append && is_tail) rule_in = add_rule;
      else if (ctl.remove && above_del) rule_in = upper_rule;
   end

   assign take = !hit_i && active && fmpf_pkg::rule_hit(rule_ff, key_i);

   always_ff @(posedge clock) begin
      rule_ff <= rule_in;
      key_ff  <= key_i;
      if (reset) begin
         kv_ff   <= 1'b0;
         hit_ff  <= 1'b0;
         pos_ff  <= '0;
         drop_ff <= 1'b0;
      end else begin
         kv_ff   <= key_vld_i;
         hit_ff  <= hit_i | take;
         pos_ff  <= take ? my_pos : pos_i;
         drop_ff <= take ? rule_ff.act : drop_i;
      end
   end

   assign rule_o    = rule_ff;
   assign key_vld_o = kv_ff;
   assign key_o     = key_ff;
   assign hit_o     = hit_ff;
   assign pos_o     = pos_ff;
   assign drop_o    = drop_ff;

endmodule

// ===== rtl/first_match_packet_filter.sv =====
// Channel   Direction  Payload                      Handshake
// req_      in         fmpf_pkg::req_type            req_valid / req_stall
// rsp_      out        fmpf_pkg::rsp_type            rsp_valid / rsp_stall
//
// A classify item enters a chain of MAX_RULES cells the cycle after it is
// accepted and moves one cell per cycle; its result is registered once it
// leaves the last cell. Add and delete update the affected slots at the same
// edge, and their result is registered at the edge after acceptance.
// One item is in flight at a time; the next is taken at the edge where the
// result leaves.
// A stalled result holds the input off until the result is taken.
// Reset is synchronous and clears the rule count and all handshake state.
// The rule slots themselves are not cleared; only live slots are compared.
module first_match_packet_filter #(
   parameter int MAX_RULES = fmpf_pkg::MaxRulesDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fmpf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fmpf_pkg::rsp_type rsp_data
);

   // Width able to hold MAX_RULES itself.
   localparam int CntW = $clog2(MAX_RULES + 1);

   fmpf_pkg::fsm_type state_ff, state_in;
   fmpf_pkg::req_type req_ff;
   logic [CntW-1:0]   total_ff, total_in;
   fmpf_pkg::rsp_type out_ff, out_in;
   logic              ov_ff, ov_in;
   fmpf_pkg::cell_ctl_type ctl;
   fmpf_pkg::rule_type add_rule;
   fmpf_pkg::key_type  key0;
   logic               accept;

   // Chain wires: element i feeds cell i.
   fmpf_pkg::rule_type rules [MAX_RULES];
   logic               kv   [MAX_RULES+1];
   fmpf_pkg::key_type  kk   [MAX_RULES+1];
   logic               hh   [MAX_RULES+1];
   logic [CntW-1:0]    pp   [MAX_RULES+1];
   logic               dd   [MAX_RULES+1];

   logic [4:0]        idx5;
   logic              idx_bad;
   logic              tcpudp;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != fmpf_pkg::FS_IDLE) || (ov_ff && rsp_stall);
   assign idx5      = req_ff.delete_index;
   assign idx_bad   = (idx5 == 5'd0) || ({{(32-5){1'b0}}, idx5} > 32'(total_ff));
   assign tcpudp    = (req_ff.packet_protocol == fmpf_pkg::ProtoTcp) ||
                      (req_ff.packet_protocol == fmpf_pkg::ProtoUdp);

   always_comb begin
      add_rule.src_addr = req_ff.source_address;
      add_rule.src_mask = req_ff.source_mask;
      add_rule.dst_addr = req_ff.dest_address;
      add_rule.dst_mask = req_ff.dest_mask;
      add_rule.sport    = req_ff.source_port;
      add_rule.dport    = req_ff.destination_port;
      add_rule.dir      = req_ff.direction;
      add_rule.proto    = req_ff.rule_protocol;
      add_rule.act      = req_ff.block_action;
      key0.dir      = req_ff.direction;
      key0.proto    = req_ff.packet_protocol;
      key0.src_addr = req_ff.source_address;
      key0.dst_addr = req_ff.dest_address;
      key0.sport    = tcpudp ? req_ff.source_port : 16'd0;
      key0.dport    = tcpudp ? req_ff.destination_port : 16'd0;
   end

   // Head of the chain. A key direction of none or three never matches: the
   // cells are made inactive for such a key, which forces a miss.
   assign kv[0] = ctl.load;
   assign kk[0] = key0;
   assign hh[0] = 1'b0;
   assign pp[0] = '0;
   assign dd[0] = 1'b0;

   for (genvar g = 0; g < MAX_RULES; g++) begin : g_cell
      fmpf_pkg::rule_type upper;
      logic               live;
      if (g == MAX_RULES - 1) begin : g_top
         assign upper = rules[g];
      end else begin : g_mid
         assign upper = rules[g+1];
      end
      assign live = (32'(g) < 32'(total_ff)) &&
                    (req_ff.direction == 2'd1 || req_ff.direction == 2'd2);
      fmpf_cell #(.IdxW(CntW)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .is_tail    (32'(g) == 32'(total_ff)),
         .above_del  (32'(g) + 32'd1 >= {{(32-5){1'b0}}, idx5}),
         .add_rule   (add_rule),
         .upper_rule (upper),
         .my_pos     (CntW'(g + 1)),
         .active     (live),
         .key_vld_i  (kv[g]),
         .key_i      (kk[g]),
         .hit_i      (hh[g]),
         .pos_i      (pp[g]),
         .drop_i     (dd[g]),
         .rule_o     (rules[g]),
         .key_vld_o  (kv[g+1]),
         .key_o      (kk[g+1]),
         .hit_o      (hh[g+1]),
         .pos_o      (pp[g+1]),
         .drop_o     (dd[g+1])
      );
   end

   always_comb begin
      state_in = state_ff;
      total_in = total_ff;
      out_in   = out_ff;
      ov_in    = ov_ff && rsp_stall;
      ctl      = '0;
      unique case (state_ff)
         fmpf_pkg::FS_IDLE: begin
            if (accept) state_in = fmpf_pkg::FS_DONE;
         end
         fmpf_pkg::FS_DONE: begin
            // Item registered; launch it.
            out_in = '0;
            unique case (fmpf_pkg::op_type'(req_ff.op))
               fmpf_pkg::OP_CLASSIFY: begin
                  ctl.load = 1'b1;
                  state_in = fmpf_pkg::FS_WALK;
               end
               fmpf_pkg::OP_ADD: begin
                  if (32'(total_ff) >= 32'(MAX_RULES)) begin
                     out_in.status = fmpf_pkg::ST_FULL;
                  end else begin
                     ctl.append = 1'b1;
                     total_in   = total_ff + CntW'(1);
                  end
                  state_in = fmpf_pkg::FS_IDLE;
               end
               fmpf_pkg::OP_DELETE: begin
                  if (idx_bad) begin
                     out_in.status = fmpf_pkg::ST_BAD_IDX;
                  end else begin
                     ctl.remove = 1'b1;
                     total_in   = total_ff - CntW'(1);
                  end
                  state_in = fmpf_pkg::FS_IDLE;
               end
               default: state_in = fmpf_pkg::FS_IDLE;
            endcase
            if (state_in == fmpf_pkg::FS_IDLE) begin
               out_in.rules_held = 5'(total_in);
               ov_in = 1'b1;
            end
         end
         fmpf_pkg::FS_WALK: begin
            if (kv[MAX_RULES]) begin
               out_in.drop           = dd[MAX_RULES];
               out_in.matched        = hh[MAX_RULES];
               out_in.match_position = 5'(pp[MAX_RULES]);
               out_in.status         = fmpf_pkg::ST_OK;
               out_in.rules_held     = 5'(total_ff);
               ov_in    = 1'b1;
               state_in = fmpf_pkg::FS_IDLE;
            end
         end
         default: state_in = fmpf_pkg::FS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) req_ff <= req_data;
      out_ff <= out_in;
      if (reset) begin
         state_ff <= fmpf_pkg::FS_IDLE;
         total_ff <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         ov_ff    <= ov_in;
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_data  = out_ff;

   a_total_max: assert property (@(posedge clock) disable iff (reset)
      32'(total_ff) <= 32'(MAX_RULES)) else $error("rule count above capacity");
   a_total_step: assert property (@(posedge clock) disable iff (reset)
      (total_ff != $past(total_ff)) |-> $past(state_ff == fmpf_pkg::FS_DONE))
      else $error("rule count moved outside an update");
   a_one_ctl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.load, ctl.append, ctl.remove})) else $error("conflicting cell controls");
   a_walk_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fmpf_pkg::FS_WALK) |-> req_stall) else $error("input open mid-walk");

endmodule
